/* rtl/lwgh_pkg.sv */
// Package for the lidar widest-gap heading block.
// Holds widths, constants, the controller state type and the command and status structs.
// No dependencies.
`default_nettype none

package lwgh_pkg;

    localparam int MAX_BEAMS   = 4096;
    localparam int RANGE_W     = 16;
    localparam int BEAM_CNT_W  = 13;
    localparam int IDX_W       = $clog2(MAX_BEAMS + 1);
    localparam int CNT_W       = $clog2(MAX_BEAMS);
    localparam int ANGLE_SCALE = 18000;
    localparam int SCALE_W     = $clog2(ANGLE_SCALE + 1);
    localparam int SPAN_W      = CNT_W + 1;
    localparam int NUM_W       = SPAN_W + SCALE_W;
    localparam int HEAD_W      = 16;
    localparam int DIV_STEPS   = NUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int HEAD_MAX    = 2 * ANGLE_SCALE;

    localparam logic [RANGE_W-1:0]    FREE_THR_RESET   = RANGE_W'(700);
    localparam logic [RANGE_W-1:0]    NEAR_CUT_RESET   = RANGE_W'(120);
    localparam logic [BEAM_CNT_W-1:0] BEAM_CNT_RESET   = BEAM_CNT_W'(360);
    localparam logic [IDX_W-1:0]      MAX_BEAMS_IDX    = IDX_W'(MAX_BEAMS);
    localparam logic [SCALE_W-1:0]    ANGLE_SCALE_C    = SCALE_W'(ANGLE_SCALE);
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST_CNT     = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [CFG_IDX_W-1:0]  CFG_FREE_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_NEAR_CUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0]  CFG_BEAM_COUNT = 2'd2;

    typedef enum logic [3:0] {
        S_RUN  = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul_start;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/lwgh_ctrl.sv */
// Controller for the lidar widest-gap heading block.
// Sequences beam intake, the heading multiply, the divide and the result load.
// Depends on lwgh_pkg.
`default_nettype none

module lwgh_ctrl
    import lwgh_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         i_last_beam,
    output logic        o_stall,
    output t_dp_cmd     o_cmd,
    input  t_dp_status  i_status
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_RUN: begin
                o_stall      = !i_rst_n;
                o_cmd.accept = i_valid;
                if (i_valid && i_last_beam) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    a_last_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_last_beam) |=> (r_state == S_MUL))
        else $error("last beam did not start the heading computation");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step || o_cmd.mul_start || o_cmd.load_out) |-> !o_cmd.accept)
        else $error("beam accepted while the result was being computed");

    a_div_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step && i_status.div_last) |=> (r_state == S_DONE))
        else $error("divide end did not reach the result state");

endmodule

`default_nettype wire

/* rtl/lwgh_dp.sv */
// Datapath for the lidar widest-gap heading block.
// Holds configuration, per-scan gap and minimum tracking, the divider and the output word.
// Depends on lwgh_pkg; driven by lwgh_ctrl.
`default_nettype none

module lwgh_dp
    import lwgh_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire  [RANGE_W-1:0]     i_range_mm,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  wire                    i_stall,
    output logic                   o_valid,
    output logic [HEAD_W-1:0]      o_heading_centideg,
    output logic [RANGE_W-1:0]     o_min_range_mm,
    output logic                   o_gap_found
);

    logic [RANGE_W-1:0]    r_free_thr;
    logic [RANGE_W-1:0]    r_near_cut;
    logic [BEAM_CNT_W-1:0] r_beam_count;

    logic [IDX_W-1:0]      r_beam_index;
    logic                  r_prev_free;
    logic [CNT_W-1:0]      r_run_length;
    logic [CNT_W-1:0]      r_best_width;
    logic [CNT_W-1:0]      r_best_end;
    logic [RANGE_W-1:0]    r_min_range;
    logic                  r_min_valid;

    logic [NUM_W-1:0]      r_quo;
    logic [IDX_W-1:0]      r_rem;
    logic [DIV_CNT_W-1:0]  r_div_cnt;

    logic                  r_out_valid;
    logic [HEAD_W-1:0]     r_out_heading;
    logic [RANGE_W-1:0]    r_out_min;
    logic                  r_out_found;

    logic [IDX_W-1:0]      eff;
    logic                  free_now;
    logic                  in_bounds;
    logic [CNT_W-1:0]      n_run_length;
    logic [CNT_W-1:0]      n_best_width;
    logic [CNT_W-1:0]      n_best_end;
    logic [RANGE_W-1:0]    n_min_range;
    logic                  n_min_valid;
    logic [SPAN_W-1:0]     span;
    logic [NUM_W-1:0]      product;
    logic [IDX_W:0]        rem_sh;
    logic                  q_bit;
    logic [IDX_W-1:0]      n_rem;

    always_comb begin
        eff = (r_beam_count > BEAM_CNT_W'(MAX_BEAMS)) ? MAX_BEAMS_IDX : IDX_W'(r_beam_count);
        free_now  = (i_range_mm > r_free_thr) || (i_range_mm == '0);
        in_bounds = (r_beam_index != '0) && (r_beam_index < eff);

        n_run_length = r_run_length;
        n_best_width = r_best_width;
        n_best_end   = r_best_end;
        if (in_bounds) begin
            if (r_prev_free && free_now) begin
                n_run_length = r_run_length + 1'b1;
            end else if (r_prev_free && !free_now && (r_run_length != '0)) begin
                if (r_run_length > r_best_width) begin
                    n_best_width = r_run_length;
                    n_best_end   = r_beam_index[CNT_W-1:0];
                end
            end else if (!r_prev_free && free_now) begin
                n_run_length = '0;
            end
        end

        n_min_range = r_min_range;
        n_min_valid = r_min_valid;
        if (i_range_mm > r_near_cut) begin
            if (!r_min_valid || (i_range_mm < r_min_range)) begin
                n_min_range = i_range_mm;
            end
            n_min_valid = 1'b1;
        end

        span    = {r_best_end, 1'b0} - {1'b0, r_best_width};
        product = NUM_W'(span * ANGLE_SCALE_C);

        rem_sh = {r_rem, r_quo[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, eff});
        n_rem  = q_bit ? IDX_W'(rem_sh - {1'b0, eff}) : rem_sh[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_thr   <= FREE_THR_RESET;
            r_near_cut   <= NEAR_CUT_RESET;
            r_beam_count <= BEAM_CNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FREE_THR:   r_free_thr   <= i_cfg_data;
                CFG_NEAR_CUT:   r_near_cut   <= i_cfg_data;
                CFG_BEAM_COUNT: r_beam_count <= i_cfg_data[BEAM_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_beam_index <= '0;
            r_prev_free  <= 1'b0;
            r_run_length <= '0;
            r_best_width <= '0;
            r_best_end   <= '0;
            r_min_range  <= '0;
            r_min_valid  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_prev_free  <= free_now;
            r_run_length <= n_run_length;
            r_best_width <= n_best_width;
            r_best_end   <= n_best_end;
            r_min_range  <= n_min_range;
            r_min_valid  <= n_min_valid;
            if (r_beam_index < MAX_BEAMS_IDX) begin
                r_beam_index <= r_beam_index + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.mul_start) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_quo <= product;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_found   <= (r_best_width != '0);
            r_out_heading <= (r_best_width != '0) ? r_quo[HEAD_W-1:0] : '0;
            r_out_min     <= r_min_valid ? r_min_range : '0;
        end
    end

    assign o_status.div_last   = (r_div_cnt == DIV_LAST_CNT);
    assign o_status.out_free   = !r_out_valid || !i_stall;
    assign o_valid             = r_out_valid;
    assign o_heading_centideg  = r_out_heading;
    assign o_min_range_mm      = r_out_min;
    assign o_gap_found         = r_out_found;

    a_clear_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> ((r_beam_index == '0) && !r_min_valid && (r_best_width == '0)))
        else $error("scan state not cleared after the result was loaded");

    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_div_cnt <= DIV_LAST_CNT))
        else $error("divide ran past its last step");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading_centideg < HEAD_W'(HEAD_MAX)))
        else $error("heading outside a full turn");

endmodule

`default_nettype wire

/* rtl/lidar_widest_gap_heading.sv */
// Lidar widest-gap heading finder, top level.
// Instantiates lwgh_ctrl and lwgh_dp; depends on lwgh_pkg.
//
// Beams arrive one word per cycle on the input channel (i_valid / o_stall) while o_stall
// is low, each a range in millimeters with a flag that marks the last beam of a scan.
// While a scan streams in, o_stall stays low and a beam is taken in every cycle with
// i_valid high. The word marked last ends the scan: the block then stalls its input while
// it multiplies the gap span by the angle scale and divides by the beam count in a
// restoring divider that yields one quotient bit per cycle over its 28-bit quotient. The
// result word appears on o_valid after the multiply, the divide and the load into the
// output register. If the receiver holds i_stall, the word is kept and the next result
// waits in the controller until the register can take it. Configuration should be written
// through i_cfg_we / i_cfg_index / i_cfg_data only between scans; the block itself does
// not enforce this. Reset holds o_stall high, restores the default registers and clears
// the scan state and the output valid flag.
`default_nettype none

module lidar_widest_gap_heading
    import lwgh_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  [RANGE_W-1:0]     i_range_mm,
    input  wire                    i_last_beam,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [HEAD_W-1:0]      o_heading_centideg,
    output logic [RANGE_W-1:0]     o_min_range_mm,
    output logic                   o_gap_found
);

    t_dp_cmd    cmd;
    t_dp_status status;

    lwgh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_beam (i_last_beam),
        .o_stall     (o_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    lwgh_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_range_mm         (i_range_mm),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_heading_centideg (o_heading_centideg),
        .o_min_range_mm     (o_min_range_mm),
        .o_gap_found        (o_gap_found)
    );

endmodule

`default_nettype wire
